// ----- sv/dual_ema_block_average_distance_defines.svh -----
// Assertion macros for the dual EMA block average distance design.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef DUAL_EMA_BLOCK_AVERAGE_DISTANCE_DEFINES_SVH
`define DUAL_EMA_BLOCK_AVERAGE_DISTANCE_DEFINES_SVH

// Consequent checked in the same cycle.
`define DEBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DEBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/deba_pkg.sv -----
// Shared types and constants for the dual EMA block average distance block.
// No dependencies.
package deba_pkg;

    localparam int unsigned BLOCK_SAMPLES_DEF = 16;
    localparam int unsigned FULL_SCALE        = 65536;
    localparam int unsigned ALPHA_ONE         = 65536;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam int unsigned MUL_A_W = 17;
    localparam int unsigned MUL_B_W = 16;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
    localparam int unsigned SUM_W   = PROD_W + 16;
    localparam int unsigned DVD_W   = 32;
    localparam int unsigned DVS_W   = 17;

    localparam logic [16:0] ALPHA_RST = 17'd6554;
    localparam logic [15:0] FLOOR_RST = 16'd0;
    localparam logic [15:0] NEAR_RST  = 16'd200;
    localparam logic [15:0] FAR_RST   = 16'd10000;

    typedef enum logic [1:0] {
        REG_ALPHA,
        REG_FLOOR,
        REG_NEAR,
        REG_FAR
    } reg_idx_t;

    typedef struct packed {
        logic [16:0] alpha;
        logic [15:0] adc_floor;
        logic [15:0] near_distance;
        logic [15:0] far_distance;
    } cfg_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL_S,
        DP_MUL_OH,
        DP_MUL_OL,
        DP_SMOOTH,
        DP_ACCUM,
        DP_AVG_TAKE,
        DP_MAP_SEL,
        DP_MAP_MUL,
        DP_MAP_DIV,
        DP_MAP_TAKE,
        DP_CLEAR,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   ch;
    } dp_cmd_t;

    typedef struct packed {
        logic ok;
        logic block_end;
        logic div_done;
        logic div_busy;
        logic map_direct;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMA_S,
        ST_EMA_OH,
        ST_EMA_OL,
        ST_EMA_SUM,
        ST_ACCUM,
        ST_AVG,
        ST_MAP_SEL,
        ST_MAP_MUL,
        ST_MAP_DIV,
        ST_MAP_WAIT,
        ST_CLEAR,
        ST_OUT
    } ctrl_state_t;

endpackage

// ----- sv/deba_regs.sv -----
// APB configuration registers: alpha, ADC floor, near and far distance.
// Depends on deba_pkg.
module deba_regs import deba_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha         <= ALPHA_RST;
            cfg_reg.adc_floor     <= FLOOR_RST;
            cfg_reg.near_distance <= NEAR_RST;
            cfg_reg.far_distance  <= FAR_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_ALPHA: cfg_reg.alpha         <= pwdata[16:0];
                REG_FLOOR: cfg_reg.adc_floor     <= pwdata[15:0];
                REG_NEAR:  cfg_reg.near_distance <= pwdata[15:0];
                REG_FAR:   cfg_reg.far_distance  <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ALPHA: prdata = APB_DATA_W'(cfg_reg.alpha);
            REG_FLOOR: prdata = APB_DATA_W'(cfg_reg.adc_floor);
            REG_NEAR:  prdata = APB_DATA_W'(cfg_reg.near_distance);
            REG_FAR:   prdata = APB_DATA_W'(cfg_reg.far_distance);
        endcase
    end

endmodule

// ----- sv/deba_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on deba_pkg.
module deba_div import deba_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             busy,
    output logic             done
);

    localparam int unsigned CNT_W = $clog2(DVD_W);

    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial    = {rem_reg, quo_reg[DVD_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DVS_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_reg <= trial[DVS_W-1:0];
            end
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

endmodule

// ----- sv/deba_dp.sv -----
// Datapath: filter state, block sums, shared multiplier, divider, output register.
// Depends on deba_pkg and deba_div.
module deba_dp import deba_pkg::*; #(
    parameter int unsigned BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    input  cfg_t        cfg,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tready,
    output dp_stat_t    st,
    output logic        m_tvalid,
    output logic [31:0] m_tdata,
    output logic [0:0]  m_tuser
);

    localparam int unsigned ACC_W = 16 + $clog2(BLOCK_SAMPLES);
    localparam int unsigned CNT_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam logic [16:0] FS_M1 = 17'(FULL_SCALE - 1);
    localparam logic [16:0] FS_V  = 17'(FULL_SCALE);
    localparam logic [16:0] A_ONE = 17'(ALPHA_ONE);
    // block average by reciprocal multiplication, exact for any sum below 2**ACC_W
    localparam int unsigned REC_S  = ACC_W + $clog2(BLOCK_SAMPLES);
    localparam int unsigned REC_W  = ACC_W + 1;
    localparam int unsigned AVG_PW = ACC_W + REC_W;
    localparam logic [REC_W-1:0] REC_M = REC_W'(((64'd1 << REC_S) + 64'(BLOCK_SAMPLES)
                                                 - 64'd1) / 64'(BLOCK_SAMPLES));

    logic [15:0]       samp_x_reg, samp_y_reg;
    logic              ok_x_reg, ok_y_reg;
    logic [31:0]       smooth_x_reg, smooth_y_reg;
    logic [ACC_W-1:0]  accum_x_reg, accum_y_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [15:0]       range_x_reg, range_y_reg;
    logic [15:0]       avg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic              fresh_reg;
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic              m_user_reg;

    logic [16:0]        alpha_sat, beta;
    logic [31:0]        smooth_c;
    logic [15:0]        samp_c;
    logic [ACC_W-1:0]   accum_c;
    logic [AVG_PW-1:0]  avg_prod;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [SUM_W-1:0]   prod_hi;
    logic [SUM_W-1:0]   smooth_sum;
    logic [15:0]        span, diff;
    logic [16:0]        den;
    logic               below_floor, at_top;
    logic [15:0]        map_val;
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic [DVD_W-1:0]   div_quo;
    logic               div_busy, div_done;

    assign alpha_sat = (cfg.alpha > A_ONE) ? A_ONE : cfg.alpha;
    assign beta      = A_ONE - alpha_sat;
    assign smooth_c  = cmd.ch ? smooth_y_reg : smooth_x_reg;
    assign samp_c    = cmd.ch ? samp_y_reg : samp_x_reg;
    assign accum_c   = cmd.ch ? accum_y_reg : accum_x_reg;
    assign avg_prod  = AVG_PW'(accum_c) * AVG_PW'(REC_M);

    assign span = (cfg.far_distance >= cfg.near_distance) ?
                  (cfg.far_distance - cfg.near_distance) : 16'd0;
    assign diff = avg_reg - cfg.adc_floor;
    assign den  = FS_V - {1'b0, cfg.adc_floor};

    assign below_floor = avg_reg <= cfg.adc_floor;
    assign at_top      = {1'b0, avg_reg} >= FS_M1;
    assign map_val     = below_floor ? cfg.near_distance : cfg.far_distance;

    always_comb begin
        case (cmd.op)
            DP_MUL_S: begin
                mul_a = alpha_sat;
                mul_b = samp_c;
            end
            DP_MUL_OH: begin
                mul_a = beta;
                mul_b = smooth_c[31:16];
            end
            DP_MUL_OL: begin
                mul_a = beta;
                mul_b = smooth_c[15:0];
            end
            default: begin
                mul_a = {1'b0, span};
                mul_b = diff;
            end
        endcase
    end

    assign prod       = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_hi    = {prod_reg, 16'd0};
    assign smooth_sum = acc_reg + SUM_W'(prod_reg);

    assign div_start = (cmd.op == DP_MAP_DIV);
    assign div_dvd   = prod_reg[DVD_W-1:0];
    assign div_dvs   = den;

    deba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_quo),
        .busy     (div_busy),
        .done     (div_done)
    );

    // filter, sums, count, distances and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_x_reg <= '0;
            smooth_y_reg <= '0;
            accum_x_reg  <= '0;
            accum_y_reg  <= '0;
            count_reg    <= '0;
            range_x_reg  <= '0;
            range_y_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            case (cmd.op)
                DP_SMOOTH: begin
                    if (cmd.ch) begin
                        smooth_y_reg <= smooth_sum[47:16];
                    end else begin
                        smooth_x_reg <= smooth_sum[47:16];
                    end
                end
                DP_ACCUM: begin
                    accum_x_reg <= accum_x_reg + ACC_W'(smooth_x_reg[31:16]);
                    accum_y_reg <= accum_y_reg + ACC_W'(smooth_y_reg[31:16]);
                    if (st.block_end) begin
                        count_reg <= '0;
                    end else begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                DP_MAP_SEL: begin
                    if (below_floor || at_top) begin
                        if (cmd.ch) begin
                            range_y_reg <= map_val;
                        end else begin
                            range_x_reg <= map_val;
                        end
                    end
                end
                DP_MAP_TAKE: begin
                    if (cmd.ch) begin
                        range_y_reg <= cfg.near_distance + div_quo[15:0];
                    end else begin
                        range_x_reg <= cfg.near_distance + div_quo[15:0];
                    end
                end
                DP_CLEAR: begin
                    accum_x_reg <= '0;
                    accum_y_reg <= '0;
                end
                default: begin
                end
            endcase
            if (cmd.op == DP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_LOAD: begin
                samp_x_reg <= s_tdata[15:0];
                samp_y_reg <= s_tdata[31:16];
                ok_x_reg   <= s_tuser[0];
                ok_y_reg   <= s_tuser[1];
            end
            DP_MUL_S: begin
                prod_reg <= prod;
            end
            DP_MUL_OH: begin
                acc_reg  <= prod_hi + SUM_W'(32768);
                prod_reg <= prod;
            end
            DP_MUL_OL: begin
                acc_reg  <= acc_reg + prod_hi;
                prod_reg <= prod;
            end
            DP_MAP_MUL: begin
                prod_reg <= prod;
            end
            DP_ACCUM: begin
                fresh_reg <= st.block_end;
            end
            DP_AVG_TAKE: begin
                avg_reg <= avg_prod[REC_S +: 16];
            end
            DP_OUT: begin
                m_data_reg <= {range_y_reg, range_x_reg};
                m_user_reg <= fresh_reg;
            end
            default: begin
            end
        endcase
    end

    assign st.ok         = cmd.ch ? ok_y_reg : ok_x_reg;
    assign st.block_end  = count_reg == CNT_W'(BLOCK_SAMPLES - 1);
    assign st.div_done   = div_done;
    assign st.div_busy   = div_busy;
    assign st.map_direct = below_floor || at_top;
    assign st.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- sv/deba_ctrl.sv -----
// Controller: sequences filter update, block average and distance mapping.
// Depends on deba_pkg.
module deba_ctrl import deba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  dp_stat_t st,
    output logic     s_tready,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        ch_reg, ch_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd.op     = DP_NOP;
        cmd.ch     = ch_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = DP_LOAD;
                    ch_next    = 1'b0;
                    state_next = ST_EMA_S;
                end
            end
            ST_EMA_S: begin
                if (st.ok) begin
                    cmd.op     = DP_MUL_S;
                    state_next = ST_EMA_OH;
                end else if (!ch_reg) begin
                    ch_next = 1'b1;
                end else begin
                    state_next = ST_ACCUM;
                end
            end
            ST_EMA_OH: begin
                cmd.op     = DP_MUL_OH;
                state_next = ST_EMA_OL;
            end
            ST_EMA_OL: begin
                cmd.op     = DP_MUL_OL;
                state_next = ST_EMA_SUM;
            end
            ST_EMA_SUM: begin
                cmd.op = DP_SMOOTH;
                if (!ch_reg) begin
                    ch_next    = 1'b1;
                    state_next = ST_EMA_S;
                end else begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                cmd.op = DP_ACCUM;
                if (st.block_end) begin
                    ch_next    = 1'b0;
                    state_next = ST_AVG;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_AVG: begin
                cmd.op     = DP_AVG_TAKE;
                state_next = ST_MAP_SEL;
            end
            ST_MAP_SEL: begin
                cmd.op = DP_MAP_SEL;
                if (!st.map_direct) begin
                    state_next = ST_MAP_MUL;
                end else if (!ch_reg) begin
                    ch_next    = 1'b1;
                    state_next = ST_AVG;
                end else begin
                    state_next = ST_CLEAR;
                end
            end
            ST_MAP_MUL: begin
                cmd.op     = DP_MAP_MUL;
                state_next = ST_MAP_DIV;
            end
            ST_MAP_DIV: begin
                cmd.op     = DP_MAP_DIV;
                state_next = ST_MAP_WAIT;
            end
            ST_MAP_WAIT: begin
                if (st.div_done) begin
                    cmd.op = DP_MAP_TAKE;
                    if (!ch_reg) begin
                        ch_next    = 1'b1;
                        state_next = ST_AVG;
                    end else begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.op     = DP_CLEAR;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (st.out_free) begin
                    cmd.op     = DP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/dual_ema_block_average_distance.sv -----
// Channel  Dir  Handshake                 Payload
// s_       in   s_tvalid / s_tready       tdata: sample_x, sample_y; tuser: x_ok, y_ok
// m_       out  m_tvalid / m_tready       tdata: distance_x, distance_y; tuser: fresh
// apb      in   psel, penable / pready    4 registers at 0x0, 0x4, 0x8, 0xC
//
// Each valid channel passes through the shared 17x16 multiplier; an invalid one is skipped.
// An item that closes a block also takes the average and clamp per channel, and the distance
// goes through the 32-step divider where it is not clamped.
// Reset is synchronous, active low; no item is taken while one is in progress.
// A stalled result is held in the output register; the next item is taken meanwhile.
// Top level; depends on deba_pkg, deba_regs, deba_ctrl, deba_dp and the defines header.
`include "dual_ema_block_average_distance_defines.svh"

module dual_ema_block_average_distance import deba_pkg::*; #(
    parameter int unsigned BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [15:0] sample_x, [31:16] sample_y
    input  logic [1:0]            s_tuser,   // [0] x_ok, [1] y_ok
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [15:0] distance_x, [31:16] distance_y
    output logic [0:0]            m_tuser,   // [0] fresh
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t st;

    deba_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    deba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .st       (st),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    deba_dp #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `DEBA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `DEBA_ASSERT_NOW(a_result_back_to_idle, $rose(m_tvalid), s_tready, "result not at idle")
    `DEBA_ASSERT_NOW(a_idle_div_quiet, s_tready, !st.div_busy, "divider busy at idle")

endmodule
